// ===== design/pfri_pkg.sv =====
package pfri_pkg;

  // Field widths
  localparam int unsigned DutyW  = 8;
  localparam int unsigned FeedW  = 16;
  localparam int unsigned InchW  = 12;
  localparam int unsigned NumW   = 24;   // |dx * df| < 2^24
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned NKnots = 3;

  // Pipeline shape: segment, product, three divider stages, saturate, convert
  localparam int unsigned DivSteps  = 8;
  localparam int unsigned DivStages = 3;
  localparam int unsigned NStages   = 7;

  // mm -> inch: floor(mm * 5 / 127) == (mm * InchMul) >> InchShift for mm < 2^16
  localparam int unsigned InchShift = 26;
  localparam int unsigned ProdW     = 38;
  localparam logic [21:0] InchMul   = 22'd2642085;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegKnot0Duty = 3'd0;
  localparam logic [2:0] RegKnot0Feed = 3'd1;
  localparam logic [2:0] RegKnot1Duty = 3'd2;
  localparam logic [2:0] RegKnot1Feed = 3'd3;
  localparam logic [2:0] RegKnot2Duty = 3'd4;
  localparam logic [2:0] RegKnot2Feed = 3'd5;

  // Reset table
  localparam logic [DutyW-1:0] Knot0DutyRst = 8'd30;
  localparam logic [FeedW-1:0] Knot0FeedRst = 16'd100;
  localparam logic [DutyW-1:0] Knot1DutyRst = 8'd127;
  localparam logic [FeedW-1:0] Knot1FeedRst = 16'd2200;
  localparam logic [DutyW-1:0] Knot2DutyRst = 8'd255;
  localparam logic [FeedW-1:0] Knot2FeedRst = 16'd22000;

  typedef logic [NKnots-1:0][DutyW-1:0] knot_duty_t;
  typedef logic [NKnots-1:0][FeedW-1:0] knot_feed_t;

  // Segment stage result
  typedef struct packed {
    logic             oor;
    logic             neg;    // quotient sign
    logic [FeedW-1:0] base;   // feed at the low end
    logic [DutyW-1:0] dx;
    logic [DutyW-1:0] dmag;
    logic [FeedW-1:0] dfmag;
  } seg_t;

  // Divider stage state; num shifts left, quotient bits enter at the bottom
  typedef struct packed {
    logic             oor;
    logic             neg;
    logic [FeedW-1:0] base;
    logic [DutyW-1:0] dmag;
    logic [DutyW-1:0] rem;
    logic [NumW-1:0]  num;
  } div_t;

endpackage

// ===== design/pfri_seg.sv =====
module pfri_seg (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pfri_pkg::DutyW-1:0]  duty_i,
  input  pfri_pkg::knot_duty_t        knot_duty_i,
  input  pfri_pkg::knot_feed_t        knot_feed_i,
  output pfri_pkg::seg_t              seg_o
);

  pfri_pkg::seg_t seg_d, seg_q;

  logic [1:0]                 hi, lo;
  logic                       below, above, same, bypass;
  logic [pfri_pkg::DutyW:0]   d;
  logic [pfri_pkg::FeedW:0]   df;
  logic [pfri_pkg::DutyW-1:0] dmag;
  logic [pfri_pkg::FeedW-1:0] dfmag;

  // Segment search: hi is first knot >= duty, lo is last knot <= duty
  always_comb begin
    below = duty_i < knot_duty_i[0];
    above = duty_i > knot_duty_i[2];

    if (knot_duty_i[0] >= duty_i) begin
      hi = 2'd0;
    end else if (knot_duty_i[1] >= duty_i) begin
      hi = 2'd1;
    end else begin
      hi = 2'd2;
    end

    if (knot_duty_i[2] <= duty_i) begin
      lo = 2'd2;
    end else if (knot_duty_i[1] <= duty_i) begin
      lo = 2'd1;
    end else begin
      lo = 2'd0;
    end

    same   = knot_duty_i[hi] == knot_duty_i[lo];
    bypass = below | above | same;

    // Signed spans, split into sign and magnitude
    d     = {1'b0, knot_duty_i[hi]} - {1'b0, knot_duty_i[lo]};
    df    = {1'b0, knot_feed_i[hi]} - {1'b0, knot_feed_i[lo]};
    dmag  = d[pfri_pkg::DutyW] ? pfri_pkg::DutyW'(-d) : d[pfri_pkg::DutyW-1:0];
    dfmag = df[pfri_pkg::FeedW] ? pfri_pkg::FeedW'(-df) : df[pfri_pkg::FeedW-1:0];

    seg_d.oor = below | above;
    seg_d.neg = d[pfri_pkg::DutyW] ^ df[pfri_pkg::FeedW];
    if (below) begin
      seg_d.base = knot_feed_i[0];
    end else if (above) begin
      seg_d.base = knot_feed_i[2];
    end else begin
      seg_d.base = knot_feed_i[lo];
    end
    // Knot hit or out of range: zero numerator over unit divisor gives q = 0
    seg_d.dx    = bypass ? '0 : duty_i - knot_duty_i[lo];
    seg_d.dmag  = bypass ? pfri_pkg::DutyW'(1) : dmag;
    seg_d.dfmag = dfmag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  assign seg_o = seg_q;

endmodule

// ===== design/pfri_mul.sv =====
module pfri_mul (
  input  logic           clk_i,
  input  logic           en_i,
  input  pfri_pkg::seg_t seg_i,
  output pfri_pkg::div_t div_o
);

  pfri_pkg::div_t div_d, div_q;

  // dx * |df|, 8 x 16 bits
  always_comb begin
    div_d.oor  = seg_i.oor;
    div_d.neg  = seg_i.neg;
    div_d.base = seg_i.base;
    div_d.dmag = seg_i.dmag;
    div_d.rem  = '0;
    div_d.num  = pfri_pkg::NumW'(seg_i.dx) * pfri_pkg::NumW'(seg_i.dfmag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ===== design/pfri_div_stage.sv =====
module pfri_div_stage (
  input  logic           clk_i,
  input  logic           en_i,
  input  pfri_pkg::div_t div_i,
  output pfri_pkg::div_t div_o
);

  pfri_pkg::div_t div_d, div_q;

  logic [pfri_pkg::DutyW:0]   trial;
  logic [pfri_pkg::DutyW-1:0] rem;
  logic [pfri_pkg::NumW-1:0]  num;

  // Restoring division, one quotient bit per step
  always_comb begin
    rem = div_i.rem;
    num = div_i.num;
    for (int unsigned i = 0; i < pfri_pkg::DivSteps; i++) begin
      trial = {rem, num[pfri_pkg::NumW-1]};
      num   = {num[pfri_pkg::NumW-2:0], 1'b0};
      if (trial >= {1'b0, div_i.dmag}) begin
        trial  = trial - {1'b0, div_i.dmag};
        num[0] = 1'b1;
      end
      rem = trial[pfri_pkg::DutyW-1:0];
    end
    div_d      = div_i;
    div_d.rem  = rem;
    div_d.num  = num;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ===== design/pfri_conv.sv =====
module pfri_conv (
  input  logic                        clk_i,
  input  logic                        en_sat_i,
  input  logic                        en_cvt_i,
  input  pfri_pkg::div_t              div_i,
  output logic [pfri_pkg::FeedW-1:0]  mm_o,
  output logic [pfri_pkg::InchW-1:0]  inch_o,
  output logic                        oor_o
);

  localparam int unsigned SumW = pfri_pkg::NumW + 2;

  logic signed [SumW-1:0]       quot, sum;
  logic [pfri_pkg::FeedW-1:0]   mm_d, mm_q, mm_out_q;
  logic                         oor_q, oor_out_q;
  logic [pfri_pkg::ProdW-1:0]   prod_d, prod_q;

  // Signed quotient plus low-end feed, clamped to 0..65535
  always_comb begin
    quot = $signed({2'b00, div_i.num});
    if (div_i.neg) begin
      quot = -quot;
    end
    sum = $signed(SumW'(div_i.base)) + quot;
    if (sum[SumW-1]) begin
      mm_d = '0;
    end else if (|sum[SumW-2:pfri_pkg::FeedW]) begin
      mm_d = '1;
    end else begin
      mm_d = sum[pfri_pkg::FeedW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sat_i) begin
      mm_q  <= mm_d;
      oor_q <= div_i.oor;
    end
  end

  // mm * 5 / 127 by reciprocal multiply
  assign prod_d = pfri_pkg::ProdW'(mm_q) * pfri_pkg::ProdW'(pfri_pkg::InchMul);

  always_ff @(posedge clk_i) begin
    if (en_cvt_i) begin
      mm_out_q  <= mm_q;
      prod_q    <= prod_d;
      oor_out_q <= oor_q;
    end
  end

  assign mm_o   = mm_out_q;
  assign inch_o = prod_q[pfri_pkg::InchShift +: pfri_pkg::InchW];
  assign oor_o  = oor_out_q;

endmodule

// ===== design/pwm_to_feed_rate_interpolator.sv =====
// Each input passes segment, product, divider, saturate and convert registers.
// Throughput: one item per cycle unless stalled; a stage holds its item while
// stalled. The 24-bit quotient takes 8 bits from each of three divider stages.
// Reset (rst_ni low, asynchronous): pipeline emptied, knot table set to
// (30,100) (127,2200) (255,22000).
module pwm_to_feed_rate_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfri_pkg::AddrW-1:0]    paddr,
  input  logic [pfri_pkg::DataW-1:0]    pwdata,
  output logic [pfri_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] duty
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [15:0] feed_mm_per_min,
                                                        // [27:16] feed_in_per_min,
                                                        // [31:28] zero
  output logic                          m_axis_tuser    // [0] out_of_range
);

  localparam int unsigned Last = pfri_pkg::NStages - 1;

  pfri_pkg::knot_duty_t knot_duty_q;
  pfri_pkg::knot_feed_t knot_feed_q;

  logic [pfri_pkg::NStages-1:0] vld_q, en;
  logic                         cfg_wr;
  logic [2:0]                   reg_idx;

  pfri_pkg::seg_t seg;
  pfri_pkg::div_t div [pfri_pkg::DivStages+1];

  logic [pfri_pkg::FeedW-1:0] mm;
  logic [pfri_pkg::InchW-1:0] inch;
  logic                       oor;

  // Config registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[pfri_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_duty_q[0] <= pfri_pkg::Knot0DutyRst;
      knot_feed_q[0] <= pfri_pkg::Knot0FeedRst;
      knot_duty_q[1] <= pfri_pkg::Knot1DutyRst;
      knot_feed_q[1] <= pfri_pkg::Knot1FeedRst;
      knot_duty_q[2] <= pfri_pkg::Knot2DutyRst;
      knot_feed_q[2] <= pfri_pkg::Knot2FeedRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        pfri_pkg::RegKnot0Duty: knot_duty_q[0] <= pwdata[pfri_pkg::DutyW-1:0];
        pfri_pkg::RegKnot0Feed: knot_feed_q[0] <= pwdata[pfri_pkg::FeedW-1:0];
        pfri_pkg::RegKnot1Duty: knot_duty_q[1] <= pwdata[pfri_pkg::DutyW-1:0];
        pfri_pkg::RegKnot1Feed: knot_feed_q[1] <= pwdata[pfri_pkg::FeedW-1:0];
        pfri_pkg::RegKnot2Duty: knot_duty_q[2] <= pwdata[pfri_pkg::DutyW-1:0];
        pfri_pkg::RegKnot2Feed: knot_feed_q[2] <= pwdata[pfri_pkg::FeedW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      pfri_pkg::RegKnot0Duty: prdata = pfri_pkg::DataW'(knot_duty_q[0]);
      pfri_pkg::RegKnot0Feed: prdata = pfri_pkg::DataW'(knot_feed_q[0]);
      pfri_pkg::RegKnot1Duty: prdata = pfri_pkg::DataW'(knot_duty_q[1]);
      pfri_pkg::RegKnot1Feed: prdata = pfri_pkg::DataW'(knot_feed_q[1]);
      pfri_pkg::RegKnot2Duty: prdata = pfri_pkg::DataW'(knot_duty_q[2]);
      pfri_pkg::RegKnot2Feed: prdata = pfri_pkg::DataW'(knot_feed_q[2]);
      default:                prdata = '0;
    endcase
  end

  // Per-stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[Last] = !vld_q[Last] || m_axis_tready;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < pfri_pkg::NStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // Stage 0: segment search
  pfri_seg u_seg (
    .clk_i       (clk_i),
    .en_i        (en[0]),
    .duty_i      (s_axis_tdata[pfri_pkg::DutyW-1:0]),
    .knot_duty_i (knot_duty_q),
    .knot_feed_i (knot_feed_q),
    .seg_o       (seg)
  );

  // Stage 1: product
  pfri_mul u_mul (
    .clk_i (clk_i),
    .en_i  (en[1]),
    .seg_i (seg),
    .div_o (div[0])
  );

  // Stages 2..4: divider
  for (genvar g = 0; g < pfri_pkg::DivStages; g++) begin : g_div
    pfri_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en[g+2]),
      .div_i (div[g]),
      .div_o (div[g+1])
    );
  end

  // Stages 5..6: saturate, inch conversion
  pfri_conv u_conv (
    .clk_i    (clk_i),
    .en_sat_i (en[Last-1]),
    .en_cvt_i (en[Last]),
    .div_i    (div[pfri_pkg::DivStages]),
    .mm_o     (mm),
    .inch_o   (inch),
    .oor_o    (oor)
  );

  assign m_axis_tvalid = vld_q[Last];
  assign m_axis_tdata  = {4'b0000, inch, mm};
  assign m_axis_tuser  = oor;

endmodule

// ===== design/pfri_chk.sv =====
module pfri_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [31:0] mm5, inch127;

  assign mm5     = {16'd0, m_axis_tdata[15:0]} * 32'd5;
  assign inch127 = {20'd0, m_axis_tdata[27:16]} * 32'd127;

  // Nothing leaves the pipeline while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // An empty output stage never blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Inch field is floor(mm * 5 / 127)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (inch127 <= mm5) && (mm5 < inch127 + 32'd127))
    else $error("inch conversion mismatch");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind pwm_to_feed_rate_interpolator pfri_chk u_pfri_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
